/* hw/rtl/edu_pkg.sv */
// Shared constants for the eikonal distance update pipeline.
// No dependencies; used by edu_front, edu_sqrt and the top level.
package edu_pkg;

  // Square-root lanes: one for the two-neighbor radicand, one for the three-neighbor radicand
  localparam int unsigned LANES      = 2;
  localparam int unsigned LANE_TWO   = 0;
  localparam int unsigned LANE_THREE = 1;

  // Integer parts of the radicand constants (2.0 and 3.0)
  localparam int unsigned RAD2_UNITS = 2;
  localparam int unsigned RAD3_UNITS = 3;

endpackage

/* hw/rtl/edu_front.sv */
// Front stages: sort neighbors, form clamped differences and squares, build radicands.
// Depends on edu_pkg.
module edu_front #(
  parameter int FRAC_BITS  = 10,
  parameter int DIST_WIDTH = 21
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            valid_i,
  output logic                                            stall_o,
  input  logic signed [DIST_WIDTH-1:0]                    dist_a_i,
  input  logic signed [DIST_WIDTH-1:0]                    dist_b_i,
  input  logic signed [DIST_WIDTH-1:0]                    dist_c_i,
  input  logic signed [DIST_WIDTH-1:0]                    cur_i,
  input  logic                                            fluid_i,
  output logic                                            valid_o,
  input  logic                                            stall_i,
  output logic signed [DIST_WIDTH-1:0]                    lo_o,
  output logic signed [DIST_WIDTH-1:0]                    hi_o,
  output logic signed [DIST_WIDTH-1:0]                    cur_o,
  output logic                                            fluid_o,
  output logic                                            two_o,
  output logic [FRAC_BITS+1:0]                            ab_o,
  output logic [FRAC_BITS+1:0]                            ac_o,
  output logic [edu_pkg::LANES-1:0][2*FRAC_BITS+1:0]      rad_o
);

  localparam int W     = DIST_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int DW    = F + 2;
  localparam int DFW   = (W + 1 > DW + 1) ? W + 1 : DW + 1;
  localparam int SQW   = 2 * DW;
  localparam int RW    = 2 * DW + 2;
  localparam int RADW  = 2 * F + 2;
  localparam int CLAMP = 1 << (F + 1);
  localparam int ONE   = 1 << F;

  // Differences beyond two units never reach a square root that is used
  function automatic logic [DW-1:0] clamp_diff(input logic signed [DFW-1:0] x);
    clamp_diff = (x > DFW'(CLAMP)) ? DW'(CLAMP) : x[DW-1:0];
  endfunction

  logic st1, st2, st3;

  // stage 1: sort
  logic                 v1_q;
  logic signed [W-1:0]  lo1_q, md1_q, hi1_q, cur1_q;
  logic                 fl1_q;
  logic signed [W-1:0]  pqlo, pqhi, mid_t, lo_d, md_d, hi_d;

  always_comb begin
    pqlo  = (dist_a_i < dist_b_i) ? dist_a_i : dist_b_i;
    pqhi  = (dist_a_i < dist_b_i) ? dist_b_i : dist_a_i;
    lo_d  = (dist_c_i < pqlo) ? dist_c_i : pqlo;
    hi_d  = (dist_c_i > pqhi) ? dist_c_i : pqhi;
    mid_t = (dist_c_i < pqhi) ? dist_c_i : pqhi;
    md_d  = (mid_t > pqlo) ? mid_t : pqlo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (!st1) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!st1) begin
      lo1_q  <= lo_d;
      md1_q  <= md_d;
      hi1_q  <= hi_d;
      cur1_q <= cur_i;
      fl1_q  <= fluid_i;
    end
  end

  // stage 2: differences, squares, one-neighbor test
  logic                 v2_q;
  logic signed [W-1:0]  lo2_q, hi2_q, cur2_q;
  logic                 fl2_q, two2_q;
  logic [DW-1:0]        ab2_q, ac2_q;
  logic [SQW-1:0]       sqab2_q, sqac2_q, sqbc2_q;
  logic signed [DFW-1:0] lo_x, md_x, hi_x;
  logic [DW-1:0]        ab_c, ac_c, bc_c;
  logic                 two_d;

  always_comb begin
    lo_x  = DFW'(lo1_q);
    md_x  = DFW'(md1_q);
    hi_x  = DFW'(hi1_q);
    ab_c  = clamp_diff(md_x - lo_x);
    ac_c  = clamp_diff(hi_x - lo_x);
    bc_c  = clamp_diff(hi_x - md_x);
    two_d = (lo_x + DFW'(ONE)) > md_x;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (!st2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!st2) begin
      lo2_q   <= lo1_q;
      hi2_q   <= hi1_q;
      cur2_q  <= cur1_q;
      fl2_q   <= fl1_q;
      two2_q  <= two_d;
      ab2_q   <= ab_c;
      ac2_q   <= ac_c;
      sqab2_q <= SQW'(ab_c) * SQW'(ab_c);
      sqac2_q <= SQW'(ac_c) * SQW'(ac_c);
      sqbc2_q <= SQW'(bc_c) * SQW'(bc_c);
    end
  end

  // stage 3: radicands, clamped at zero
  logic                 v3_q;
  logic signed [W-1:0]  lo3_q, hi3_q, cur3_q;
  logic                 fl3_q, two3_q;
  logic [DW-1:0]        ab3_q, ac3_q;
  logic [edu_pkg::LANES-1:0][RADW-1:0] rad3_q;
  logic [RW-1:0]        r2, r3;

  always_comb begin
    r2 = (RW'(edu_pkg::RAD2_UNITS) << (2 * F)) - RW'(sqab2_q);
    r3 = (RW'(edu_pkg::RAD3_UNITS) << (2 * F))
         - (RW'(sqab2_q) + RW'(sqac2_q) + RW'(sqbc2_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (!st3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!st3) begin
      lo3_q  <= lo2_q;
      hi3_q  <= hi2_q;
      cur3_q <= cur2_q;
      fl3_q  <= fl2_q;
      two3_q <= two2_q;
      ab3_q  <= ab2_q;
      ac3_q  <= ac2_q;
      rad3_q[edu_pkg::LANE_TWO]   <= r2[RW-1] ? '0 : r2[RADW-1:0];
      rad3_q[edu_pkg::LANE_THREE] <= r3[RW-1] ? '0 : r3[RADW-1:0];
    end
  end

  assign st3     = v3_q & stall_i;
  assign st2     = v2_q & st3;
  assign st1     = v1_q & st2;
  assign stall_o = st1;

  assign valid_o = v3_q;
  assign lo_o    = lo3_q;
  assign hi_o    = hi3_q;
  assign cur_o   = cur3_q;
  assign fluid_o = fl3_q;
  assign two_o   = two3_q;
  assign ab_o    = ab3_q;
  assign ac_o    = ac3_q;
  assign rad_o   = rad3_q;

endmodule

/* hw/rtl/edu_sqrt.sv */
// Pipelined floor square root, one root bit per stage, several lanes in step.
// Depends on edu_pkg; carries an opaque sideband word alongside.
module edu_sqrt #(
  parameter int ROOT_BITS  = 11,
  parameter int SIDE_WIDTH = 1
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          valid_i,
  output logic                                          stall_o,
  input  logic [edu_pkg::LANES-1:0][2*ROOT_BITS-1:0]    rad_i,
  input  logic [SIDE_WIDTH-1:0]                         side_i,
  output logic                                          valid_o,
  input  logic                                          stall_i,
  output logic [edu_pkg::LANES-1:0][ROOT_BITS-1:0]      root_o,
  output logic [SIDE_WIDTH-1:0]                         side_o
);

  localparam int N     = ROOT_BITS;
  localparam int RMW   = 2 * N + 1;
  localparam int LN    = edu_pkg::LANES;

  logic [N:0]                     stl;
  logic                           v_q    [N];
  logic [LN-1:0][RMW-1:0]         rem_q  [N];
  logic [LN-1:0][N-1:0]           root_q [N];
  logic [SIDE_WIDTH-1:0]          side_q [N];

  assign stl[N] = stall_i;

  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam int B = N - 1 - j;
    logic                   vin;
    logic [SIDE_WIDTH-1:0]  sin;
    logic [LN-1:0][RMW-1:0] rin, rnx, trial;
    logic [LN-1:0][N-1:0]   qin, qnx;
    logic [LN-1:0]          take;

    if (j == 0) begin : g_first
      assign vin = valid_i;
      assign sin = side_i;
      for (genvar l = 0; l < LN; l++) begin : g_lane
        assign rin[l] = RMW'(rad_i[l]);
        assign qin[l] = '0;
      end
    end else begin : g_next
      assign vin = v_q[j-1];
      assign sin = side_q[j-1];
      assign rin = rem_q[j-1];
      assign qin = root_q[j-1];
    end

    // try setting root bit B
    always_comb begin
      for (int l = 0; l < LN; l++) begin
        trial[l] = (RMW'(qin[l]) << (B + 1)) + (RMW'(1) << (2 * B));
        take[l]  = rin[l] >= trial[l];
        rnx[l]   = take[l] ? (rin[l] - trial[l]) : rin[l];
        qnx[l]   = take[l] ? (qin[l] | (N'(1) << B)) : qin[l];
      end
    end

    assign stl[j] = v_q[j] & stl[j+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (!stl[j]) begin
        v_q[j] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (!stl[j]) begin
        rem_q[j]  <= rnx;
        root_q[j] <= qnx;
        side_q[j] <= sin;
      end
    end
  end

  assign stall_o = stl[0];
  assign valid_o = v_q[N-1];
  assign root_o  = root_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

/* hw/rtl/edu_back.sv */
// Back stages: two- and three-neighbor candidates, floor division by three, final minimum.
// No package dependencies; fed by edu_sqrt.
module edu_back #(
  parameter int FRAC_BITS  = 10,
  parameter int DIST_WIDTH = 21
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         stall_o,
  input  logic signed [DIST_WIDTH-1:0] lo_i,
  input  logic signed [DIST_WIDTH-1:0] hi_i,
  input  logic signed [DIST_WIDTH-1:0] cur_i,
  input  logic                         fluid_i,
  input  logic                         two_i,
  input  logic [FRAC_BITS+1:0]         ab_i,
  input  logic [FRAC_BITS+1:0]         ac_i,
  input  logic [FRAC_BITS:0]           s2_i,
  input  logic [FRAC_BITS:0]           s3_i,
  output logic                         valid_o,
  input  logic                         stall_i,
  output logic [DIST_WIDTH-1:0]        new_dist_o
);

  localparam int W    = DIST_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int DW   = F + 2;
  localparam int RB   = DW + 2;
  localparam int EW   = ((W > DW) ? W : DW) + 2;
  localparam int K    = RB + 2;
  localparam int PW   = RB + K;
  localparam int DIV  = 3;
  localparam int MULT = (2 ** K) / DIV;
  localparam int ONE  = 1 << F;

  logic stA, stB, stC, stD;

  // stage A: half of two-neighbor offset, three-neighbor offset sum
  logic                vA_q;
  logic signed [W-1:0] loA_q, hiA_q, curA_q;
  logic                flA_q, twoA_q;
  logic [DW-1:0]       h2A_q;
  logic [RB-1:0]       rA_q;
  logic [DW:0]         h2_sum;

  assign h2_sum = (DW+1)'(ab_i) + (DW+1)'(s2_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vA_q <= 1'b0;
    end else if (!stA) begin
      vA_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stA) begin
      loA_q  <= lo_i;
      hiA_q  <= hi_i;
      curA_q <= cur_i;
      flA_q  <= fluid_i;
      twoA_q <= two_i;
      h2A_q  <= h2_sum[DW:1];
      rA_q   <= RB'(ab_i) + RB'(ac_i) + RB'(s3_i);
    end
  end

  // stage B: two-neighbor result, its test against hi, reciprocal multiply
  logic                 vB_q;
  logic signed [W-1:0]  loB_q, curB_q;
  logic                 flB_q, twoB_q, threeB_q;
  logic signed [EW-1:0] d2B_q, d2;
  logic [RB-1:0]        rB_q, q0B_q;
  logic [PW-1:0]        prod;

  assign d2   = EW'(loA_q) + $signed(EW'(h2A_q));
  assign prod = PW'(rA_q) * PW'(MULT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vB_q <= 1'b0;
    end else if (!stB) begin
      vB_q <= vA_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stB) begin
      loB_q    <= loA_q;
      curB_q   <= curA_q;
      flB_q    <= flA_q;
      twoB_q   <= twoA_q;
      threeB_q <= twoA_q & (d2 > EW'(hiA_q));
      d2B_q    <= d2;
      rB_q     <= rA_q;
      q0B_q    <= prod[PW-1:K];
    end
  end

  // stage C: correct the quotient estimate by at most one
  logic                 vC_q;
  logic signed [W-1:0]  loC_q, curC_q;
  logic                 flC_q, twoC_q, threeC_q;
  logic signed [EW-1:0] d2C_q;
  logic [RB-1:0]        q3C_q;
  logic [RB+1:0]        rem;

  assign rem = (RB+2)'(rB_q) - ((RB+2)'(q0B_q) + ((RB+2)'(q0B_q) << 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vC_q <= 1'b0;
    end else if (!stC) begin
      vC_q <= vB_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stC) begin
      loC_q    <= loB_q;
      curC_q   <= curB_q;
      flC_q    <= flB_q;
      twoC_q   <= twoB_q;
      threeC_q <= threeB_q;
      d2C_q    <= d2B_q;
      q3C_q    <= q0B_q + RB'(rem >= (RB+2)'(DIV));
    end
  end

  // stage D: pick candidate, take minimum with current (fluid cells keep current), output register
  logic                 vD_q;
  logic [W-1:0]         new_dist_q;
  logic signed [EW-1:0] d1, d3, cand, res;

  always_comb begin
    d1   = EW'(loC_q) + EW'(ONE);
    d3   = EW'(loC_q) + $signed(EW'(q3C_q));
    cand = threeC_q ? d3 : (twoC_q ? d2C_q : d1);
    res  = (!flC_q && (cand < EW'(curC_q))) ? cand : EW'(curC_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vD_q <= 1'b0;
    end else if (!stD) begin
      vD_q <= vC_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stD) begin
      new_dist_q <= res[W-1:0];
    end
  end

  assign stD     = vD_q & stall_i;
  assign stC     = vC_q & stD;
  assign stB     = vB_q & stC;
  assign stA     = vA_q & stB;
  assign stall_o = stA;

  assign valid_o    = vD_q;
  assign new_dist_o = new_dist_q;

endmodule

/* hw/rtl/eikonal_distance_update.sv */
// Top level of the 3D fast sweeping eikonal cell update.
// Depends on edu_pkg, edu_front, edu_sqrt and edu_back.
//
// Usage:
//   Input channel: dist_a_i, dist_b_i, dist_c_i, current_dist_i, is_fluid_i with
//   valid_i / stall_o. A word is taken at a clock edge with valid_i high and
//   stall_o low. Output channel: new_dist_o with valid_o / stall_i, one result
//   word per input word, in order.
//   Pipeline: three front stages, one square-root stage per root bit (FRAC_BITS + 1,
//   both radicands side by side), four back stages ending in the output
//   register.
//   Throughput: one word per cycle while the output is not stalled.
//   Every stage carries its own valid bit and holds while it is full and the
//   stage after it is stalled, so bubbles are squeezed out and stall_o rises only
//   once the whole pipeline is full behind a stalled output.
//   Reset clears all valid bits; the pipeline comes up empty.
module eikonal_distance_update #(
  parameter int FRAC_BITS  = 10,
  parameter int DIST_WIDTH = 21
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         stall_o,
  input  logic signed [DIST_WIDTH-1:0] dist_a_i,
  input  logic signed [DIST_WIDTH-1:0] dist_b_i,
  input  logic signed [DIST_WIDTH-1:0] dist_c_i,
  input  logic signed [DIST_WIDTH-1:0] current_dist_i,
  input  logic                         is_fluid_i,
  output logic                         valid_o,
  input  logic                         stall_i,
  output logic signed [DIST_WIDTH-1:0] new_dist_o
);

  localparam int W    = DIST_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int DW   = F + 2;
  localparam int N    = F + 1;
  localparam int RADW = 2 * N;
  localparam int SW   = 3 * W + 2 + 2 * DW;
  localparam int LN   = edu_pkg::LANES;

  logic                     f_valid, f_stall;
  logic signed [W-1:0]      f_lo, f_hi, f_cur;
  logic                     f_fluid, f_two;
  logic [DW-1:0]            f_ab, f_ac;
  logic [LN-1:0][RADW-1:0]  f_rad;

  logic                     s_valid, s_stall;
  logic [SW-1:0]            s_side_in, s_side_out;
  logic [LN-1:0][N-1:0]     s_root;

  logic signed [W-1:0]      b_lo, b_hi, b_cur;
  logic                     b_fluid, b_two;
  logic [DW-1:0]            b_ab, b_ac;
  logic [W-1:0]             new_dist;

  edu_front #(
    .FRAC_BITS  (F),
    .DIST_WIDTH (W)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_i),
    .stall_o  (stall_o),
    .dist_a_i (dist_a_i),
    .dist_b_i (dist_b_i),
    .dist_c_i (dist_c_i),
    .cur_i    (current_dist_i),
    .fluid_i  (is_fluid_i),
    .valid_o  (f_valid),
    .stall_i  (f_stall),
    .lo_o     (f_lo),
    .hi_o     (f_hi),
    .cur_o    (f_cur),
    .fluid_o  (f_fluid),
    .two_o    (f_two),
    .ab_o     (f_ab),
    .ac_o     (f_ac),
    .rad_o    (f_rad)
  );

  assign s_side_in = {f_lo, f_hi, f_cur, f_fluid, f_two, f_ab, f_ac};

  edu_sqrt #(
    .ROOT_BITS  (N),
    .SIDE_WIDTH (SW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .stall_o (f_stall),
    .rad_i   (f_rad),
    .side_i  (s_side_in),
    .valid_o (s_valid),
    .stall_i (s_stall),
    .root_o  (s_root),
    .side_o  (s_side_out)
  );

  assign {b_lo, b_hi, b_cur, b_fluid, b_two, b_ab, b_ac} = s_side_out;

  edu_back #(
    .FRAC_BITS  (F),
    .DIST_WIDTH (W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s_valid),
    .stall_o    (s_stall),
    .lo_i       (b_lo),
    .hi_i       (b_hi),
    .cur_i      (b_cur),
    .fluid_i    (b_fluid),
    .two_i      (b_two),
    .ab_i       (b_ab),
    .ac_i       (b_ac),
    .s2_i       (s_root[edu_pkg::LANE_TWO]),
    .s3_i       (s_root[edu_pkg::LANE_THREE]),
    .valid_o    (valid_o),
    .stall_i    (stall_i),
    .new_dist_o (new_dist)
  );

  assign new_dist_o = $signed(new_dist);

endmodule
